// File: design/cfck_pkg.sv
// ----------------------------------------------------------------------------
// cfck_pkg
// Shared types, codes and the CRC-8 byte step for the response frame checker.
// ----------------------------------------------------------------------------
package cfck_pkg;

    // Largest payload a frame may announce
    localparam logic [10:0] MAX_PAYLOAD = 11'd512;

    // CRC-8, polynomial 0x31, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Special header values
    localparam logic [6:0] BULK_READ_CODE = 7'h1D;
    localparam logic [7:0] ANY_ADDRESS    = 8'hFF;
    localparam logic [7:0] BULK_CNT_400   = 8'hFF;
    localparam logic [7:0] BULK_CNT_200   = 8'hC8;
    localparam logic [9:0] BULK_LEN_400   = 10'd400;
    localparam logic [9:0] BULK_LEN_200   = 10'd200;

    // Input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Configuration register indexes
    localparam logic CFG_DEV_ADDR          = 1'b0;
    localparam logic CFG_EXPECTED_FUNCTION = 1'b1;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_BADLEN    = 3'd3;
    localparam logic [2:0] ST_CRC       = 3'd4;
    localparam logic [2:0] ST_EXCEPTION = 3'd5;

    // One result beat
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [8:0] payload_index;
        logic       frame_done;
        logic [2:0] status;
        logic [7:0] exc_code;
        logic [9:0] payload_length;
    } cfck_result_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0] dev_addr;
        logic [6:0] expected_function;
    } cfck_cfg_t;

    // Fold one byte into the running CRC
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/cfck_if.sv
// ----------------------------------------------------------------------------
// cfck interfaces
// Valid/ready channels for input beats, result beats and configuration writes.
// ----------------------------------------------------------------------------
interface cfck_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface cfck_rsp_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [8:0] payload_index;
    logic       frame_done;
    logic [2:0] status;
    logic [7:0] exc_code;
    logic [9:0] payload_length;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output frame_done, output status,
                    output exc_code, output payload_length, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input payload_index, input frame_done, input status,
                    input exc_code, input payload_length, output ready);
endinterface

interface cfck_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/cfck_parse.sv
// ----------------------------------------------------------------------------
// cfck_parse
// Frame state and the per-beat parse: header, payload, CRC and status check.
// ----------------------------------------------------------------------------
module cfck_parse
    import cfck_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         op,
    input  logic [7:0]   rx_byte,
    input  cfck_cfg_t    cfg,
    output cfck_result_t result
);

    logic       in_payload_reg,  in_payload_next;
    logic [9:0] byte_count_reg,  byte_count_next;
    logic [7:0] crc_reg,         crc_next;
    logic [7:0] hdr_addr_reg,    hdr_addr_next;
    logic [7:0] hdr_func_reg,    hdr_func_next;
    logic [7:0] hdr_count_reg,   hdr_count_next;
    logic [9:0] exp_len_reg,     exp_len_next;
    logic [7:0] first_pl_reg,    first_pl_next;

    logic [7:0] crc_upd;
    logic [9:0] len;
    logic       bulk;

    assign crc_upd = crc8_step(crc_reg, rx_byte);
    assign bulk    = (cfg.expected_function == BULK_READ_CODE);

    // Decode the announced length from the count byte
    always_comb
    begin
        len = {2'b00, rx_byte};
        if (bulk && rx_byte == BULK_CNT_400)
            len = BULK_LEN_400;
        else if (bulk && rx_byte == BULK_CNT_200)
            len = BULK_LEN_200;
    end

    // Work out the result beat and the next frame state
    always_comb
    begin
        result          = '0;
        in_payload_next = in_payload_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        hdr_addr_next   = hdr_addr_reg;
        hdr_func_next   = hdr_func_reg;
        hdr_count_next  = hdr_count_reg;
        exp_len_next    = exp_len_reg;
        first_pl_next   = first_pl_reg;

        if (op == OP_TIMEOUT) begin
            result.frame_done     = 1'b1;
            result.status         = (byte_count_reg == '0) ? ST_TIMEOUT : ST_INVALID;
            result.payload_length = in_payload_reg ? exp_len_reg : '0;
            in_payload_next       = 1'b0;
            byte_count_next       = '0;
            crc_next              = '0;
        end else if (!in_payload_reg) begin
            crc_next = crc_upd;
            if (byte_count_reg == 10'd0) begin
                hdr_addr_next   = rx_byte;
                byte_count_next = 10'd1;
            end else if (byte_count_reg == 10'd1) begin
                hdr_func_next   = rx_byte;
                byte_count_next = 10'd2;
            end else begin
                hdr_count_next = rx_byte;
                if (hdr_addr_reg != cfg.dev_addr && cfg.dev_addr != ANY_ADDRESS)
                begin
                    result.frame_done = 1'b1;
                    result.status     = ST_INVALID;
                    byte_count_next   = '0;
                    crc_next          = '0;
                end else begin
                    exp_len_next          = len;
                    result.payload_length = len;
                    if ({1'b0, len} > MAX_PAYLOAD) begin
                        result.frame_done = 1'b1;
                        result.status     = ST_BADLEN;
                        byte_count_next   = '0;
                        crc_next          = '0;
                    end else begin
                        in_payload_next = 1'b1;
                        byte_count_next = '0;
                    end
                end
            end
        end else begin
            result.payload_length = exp_len_reg;
            if (byte_count_reg < exp_len_reg) begin
                // Pass the payload byte through and fold it into the CRC
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = byte_count_reg[8:0];
                if (byte_count_reg == '0)
                    first_pl_next = rx_byte;
                crc_next        = crc_upd;
                byte_count_next = byte_count_reg + 10'd1;
            end else begin
                // CRC byte: close the frame
                result.frame_done = 1'b1;
                if (rx_byte != crc_reg)
                    result.status = ST_CRC;
                else if (hdr_func_reg[7]) begin
                    if (hdr_count_reg == 8'd1 && exp_len_reg == 10'd1) begin
                        result.status   = ST_EXCEPTION;
                        result.exc_code = first_pl_reg;
                    end else
                        result.status = ST_INVALID;
                end else if (hdr_func_reg[6:0] != cfg.expected_function)
                    result.status = ST_INVALID;
                else
                    result.status = ST_OK;
                in_payload_next = 1'b0;
                byte_count_next = '0;
                crc_next        = '0;
            end
        end
    end

    // Advance the frame state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_payload_reg <= 1'b0;
            byte_count_reg <= '0;
            crc_reg        <= '0;
            hdr_addr_reg   <= '0;
            hdr_func_reg   <= '0;
            hdr_count_reg  <= '0;
            exp_len_reg    <= '0;
            first_pl_reg   <= '0;
        end else if (accept) begin
            in_payload_reg <= in_payload_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            hdr_addr_reg   <= hdr_addr_next;
            hdr_func_reg   <= hdr_func_next;
            hdr_count_reg  <= hdr_count_next;
            exp_len_reg    <= exp_len_next;
            first_pl_reg   <= first_pl_next;
        end
    end

endmodule

// File: design/cfck_out_reg.sv
// ----------------------------------------------------------------------------
// cfck_out_reg
// Result register: holds one beat for the receiver, refills while draining.
// ----------------------------------------------------------------------------
module cfck_out_reg
    import cfck_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  cfck_result_t  result,
    output logic          can_load,
    cfck_rsp_if.source    rsp
);

    logic         valid_reg;
    cfck_result_t data_reg;

    // Take a new beat when empty or when the current one leaves this cycle
    assign can_load = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (can_load && load)
            data_reg <= result;
    end

    assign rsp.valid          = valid_reg;
    assign rsp.payload_valid  = data_reg.payload_valid;
    assign rsp.payload_byte   = data_reg.payload_byte;
    assign rsp.payload_index  = data_reg.payload_index;
    assign rsp.frame_done     = data_reg.frame_done;
    assign rsp.status         = data_reg.status;
    assign rsp.exc_code       = data_reg.exc_code;
    assign rsp.payload_length = data_reg.payload_length;

endmodule

// File: design/crc8_response_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8_response_frame_checker
// Deframes a serial response (address, function, count, payload, CRC-8).
//
// Channels: req carries one received byte (op = byte) or a read-timeout event
// (op = timeout) per beat; rsp returns exactly one result beat per req beat,
// either a payload byte with its index, the final status of the frame, or an empty beat for a header byte.
// cfg writes the device address (index 0) and expected_function (index 1); it
// is always ready and should be written only while the block is idle.
// Results: a result is registered and appears in the cycle after its req beat is accepted.
// Throughput: one beat per cycle while rsp is not held off; the frame state and
// CRC-8 byte step close combinationally ahead of the result register.
// Stall: while rsp is held off, the result register keeps its beat and req
// takes a beat only while the register is empty.
// Reset: frame state returns to the header phase with a zero CRC; device
// address resets to 1 and expected function to 0.
// ----------------------------------------------------------------------------
module crc8_response_frame_checker
    import cfck_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cfck_cfg_if.sink   cfg,
    cfck_req_if.sink   req,
    cfck_rsp_if.source rsp
);

    logic [7:0]   dev_addr_reg;
    logic [6:0]   expected_function_reg;
    cfck_cfg_t    cfg_val;
    cfck_result_t result;
    logic         can_load;
    logic         accept;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dev_addr_reg          <= 8'd1;
            expected_function_reg <= 7'd0;
        end else if (cfg.valid) begin
            case (cfg.index)
                CFG_DEV_ADDR:          dev_addr_reg          <= cfg.data;
                CFG_EXPECTED_FUNCTION: expected_function_reg <= cfg.data[6:0];
                default:               dev_addr_reg          <= dev_addr_reg;
            endcase
        end
    end

    assign cfg_val.dev_addr          = dev_addr_reg;
    assign cfg_val.expected_function = expected_function_reg;

    // Accept a beat whenever the result register can take its result
    assign req.ready = can_load;
    assign accept    = req.valid && can_load;

    cfck_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (req.op),
        .rx_byte (req.rx_byte),
        .cfg     (cfg_val),
        .result  (result)
    );

    cfck_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule

// File: design/cfck_checker.sv
// ----------------------------------------------------------------------------
// cfck_checker
// Port-level checks on the response frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module cfck_checker
    import cfck_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       payload_valid,
    input logic       frame_done,
    input logic [2:0] status,
    input logic [7:0] exc_code,
    input logic [9:0] payload_length
);

    // Every accepted beat yields a result on the next cycle
    a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no result after accepted beat");

    // A beat is either payload or frame end, never both
    a_payload_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(payload_valid && frame_done))
        else $error("payload and frame end on one beat");

    // Status and exception code stay zero away from frame ends
    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !frame_done |-> status == ST_OK && exc_code == 8'd0)
        else $error("status on a non-final beat");

    // Device exception only on a one-byte payload
    a_exception_length: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && frame_done && status == ST_EXCEPTION |-> payload_length == 10'd1)
        else $error("exception frame with wrong length");

    // Stalled result stays presented
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(frame_done))
        else $error("result dropped while stalled");

endmodule

bind crc8_response_frame_checker cfck_checker u_cfck_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .payload_valid  (rsp.payload_valid),
    .frame_done     (rsp.frame_done),
    .status         (rsp.status),
    .exc_code       (rsp.exc_code),
    .payload_length (rsp.payload_length)
);
